// ----- rtl/hcd_pkg.sv -----
// Shared types, codes and tables of the Harris corner detector.
package hcd_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 8;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int PIX_W  = 8;
    localparam int GEO_W  = 9;
    localparam int K_W    = 16;
    localparam int THR_W  = 17;
    localparam int CFG_W  = 17;
    localparam int RESP_W = 48;
    localparam int NORM_W = 17;

    localparam logic [GEO_W-1:0] MAX_WIDTH  = 9'd256;
    localparam logic [GEO_W-1:0] MAX_HEIGHT = 9'd256;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_DONE = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    localparam logic [1:0] REG_FRAME_WIDTH      = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_HARRIS_K         = 2'd2;
    localparam logic [1:0] REG_CORNER_THRESHOLD = 2'd3;

    localparam logic [1:0] OFF_PREV = 2'd0;
    localparam logic [1:0] OFF_SAME = 2'd1;
    localparam logic [1:0] OFF_NEXT = 2'd2;

    typedef struct packed {
        logic              action;
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  query_col;
        logic [ROW_W-1:0]  query_row;
    } item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [RESP_W-1:0] response;
        logic [NORM_W-1:0]        normalized;
        logic                     is_corner;
    } result_t;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
    } geom_t;

    typedef struct packed {
        logic              is_query;
        logic              first;
        logic              last;
        logic              outside;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
    } cmd_t;

    function automatic logic [1:0] nb_row(input logic [4:0] idx);
        logic [1:0] r;
        r = OFF_NEXT;
        if (idx < 5'd3)
            r = OFF_PREV;
        else if (idx < 5'd6)
            r = OFF_SAME;
        return r;
    endfunction

    function automatic logic [1:0] nb_col(input logic [4:0] idx);
        logic [1:0] r;
        unique case (idx)
            5'd0, 5'd3, 5'd6: r = OFF_PREV;
            5'd1, 5'd4, 5'd7: r = OFF_SAME;
            default:          r = OFF_NEXT;
        endcase
        return r;
    endfunction

    function automatic logic signed [2:0] sobel_wx(input logic [4:0] idx);
        logic signed [2:0] w;
        unique case (idx)
            5'd0, 5'd6: w = -3'sd1;
            5'd2, 5'd8: w = 3'sd1;
            5'd3:       w = -3'sd2;
            5'd5:       w = 3'sd2;
            default:    w = 3'sd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [2:0] sobel_wy(input logic [4:0] idx);
        logic signed [2:0] w;
        unique case (idx)
            5'd0, 5'd2: w = -3'sd1;
            5'd1:       w = -3'sd2;
            5'd6, 5'd8: w = 3'sd1;
            5'd7:       w = 3'sd2;
            default:    w = 3'sd0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/hcd_front.sv -----
// Front part: geometry, raster write position and classification of items.
module hcd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [hcd_pkg::GEO_W-1:0] frame_width,
    input  logic [hcd_pkg::GEO_W-1:0] frame_height,
    input  logic                      restart,
    input  hcd_pkg::item_t            item,
    input  logic                      item_valid,
    output logic                      item_stall,
    output hcd_pkg::cmd_t             cmd,
    output logic                      cmd_valid,
    input  logic                      cmd_stall,
    output hcd_pkg::geom_t            geom
);
    import hcd_pkg::*;

    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [ROW_W-1:0] row_reg, row_next, cur_row;
    logic             accept;
    logic             end_col;

    always_comb
    begin
        if (frame_width < 9'd2)
            geom.last_col = 8'd1;
        else if (frame_width > MAX_WIDTH)
            geom.last_col = COL_W'(MAX_WIDTH - 9'd1);
        else
            geom.last_col = COL_W'(frame_width - 9'd1);
        if (frame_height < 9'd2)
            geom.last_row = 8'd1;
        else if (frame_height > MAX_HEIGHT)
            geom.last_row = ROW_W'(MAX_HEIGHT - 9'd1);
        else
            geom.last_row = ROW_W'(frame_height - 9'd1);
    end

    always_comb
    begin
        if (col_reg > geom.last_col || row_reg > geom.last_row)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else
        begin
            cur_col = col_reg;
            cur_row = row_reg;
        end
    end

    assign end_col      = (cur_col == geom.last_col);
    assign accept       = item_valid && !cmd_stall;
    assign cmd_valid    = item_valid;
    assign item_stall   = cmd_stall;

    assign cmd.is_query = (item.action == ACT_QUERY);
    assign cmd.first    = (cur_col == '0) && (cur_row == '0);
    assign cmd.last     = end_col && (cur_row == geom.last_row);
    assign cmd.outside  = (item.query_col > geom.last_col) || (item.query_row > geom.last_row);
    assign cmd.addr     = cmd.is_query ? {item.query_row, item.query_col} : {cur_row, cur_col};
    assign cmd.pixel    = item.pixel;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && item.action == ACT_PIXEL)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = (cur_row == geom.last_row) ? '0 : cur_row + 1'b1;
            end
            else
            begin
                col_next = cur_col + 1'b1;
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/hcd_queue.sv -----
// Short command queue between the front and back parts.
module hcd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  hcd_pkg::cmd_t push_cmd,
    input  logic          push_valid,
    output logic          push_stall,
    output hcd_pkg::cmd_t pop_cmd,
    output logic          pop_valid,
    input  logic          pop_stall
);
    import hcd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_stall = (count_reg == (PTR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/hcd_back.sv -----
// Back part: pixel and response stores, frame compute sequencer, query unit.
module hcd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  hcd_pkg::geom_t            geom,
    input  logic [hcd_pkg::K_W-1:0]   harris_k,
    input  logic [hcd_pkg::THR_W-1:0] corner_threshold,
    input  hcd_pkg::cmd_t             cmd,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    output hcd_pkg::result_t          result,
    output logic                      result_valid,
    input  logic                      result_stall
);
    import hcd_pkg::*;

    localparam int CELLS = 1 << ADDR_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SOBEL  = 3'd1;
    localparam logic [2:0] S_HARRIS = 3'd2;
    localparam logic [2:0] S_QREAD  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]       state_reg;
    logic [4:0]       step_reg;
    logic [COL_W-1:0] cx_reg;
    logic [ROW_W-1:0] cy_reg;
    logic             frame_done_reg;
    logic             res_valid_reg;
    result_t          result_reg;

    logic [PIX_W-1:0]         pix_mem  [CELLS];
    logic [19:0]              xx_mem   [CELLS];
    logic signed [20:0]       xy_mem   [CELLS];
    logic [19:0]              yy_mem   [CELLS];
    logic signed [RESP_W-1:0] resp_mem [CELLS];

    logic [PIX_W-1:0]         pix_rdata_reg;
    logic [19:0]              xx_rdata_reg, yy_rdata_reg;
    logic signed [20:0]       xy_rdata_reg;
    logic signed [RESP_W-1:0] resp_rdata_reg;

    logic signed [10:0]       gx_reg, gy_reg;
    logic [21:0]              a_reg, c_reg;
    logic signed [22:0]       b_reg;
    logic [43:0]              ac_reg, bb_reg;
    logic [45:0]              ss_reg;
    logic [38:0]              pk_lo_reg, pk_hi_reg;
    logic signed [44:0]       diff_reg;
    logic [45:0]              kterm_reg;
    logic signed [RESP_W-1:0] r_new_reg, min_reg, max_reg, r_reg;
    logic [RESP_W:0]          rem_reg;
    logic [RESP_W-1:0]        span_reg;
    logic [NORM_W-1:0]        q_reg;
    logic                     spread_reg;
    logic [1:0]               status_reg;

    logic [ROW_W-1:0] row_prev, row_next, nb_r;
    logic [COL_W-1:0] col_prev, col_next, nb_c;
    logic [ADDR_W-1:0] pix_raddr, prod_raddr, here;
    logic [4:0]        nb_idx;
    logic signed [10:0] pix_s, wx_s, wy_s;
    logic signed [21:0] gx_w, gy_w;
    logic [43:0]       a_w, c_w;
    logic signed [45:0] b_w;
    logic [45:0]       s_w;
    logic [38:0]       k_w;
    logic [61:0]       kfull;
    logic              pix_we, prod_we, resp_we;
    logic              pop, cell_first, frame_end, spread, load_out;
    logic [RESP_W:0]   trial, span_w;
    logic              ge;

    assign here       = {cy_reg, cx_reg};
    assign row_prev   = (cy_reg == '0) ? 8'd1 : cy_reg - 1'b1;
    assign row_next   = (cy_reg == geom.last_row) ? geom.last_row - 1'b1 : cy_reg + 1'b1;
    assign col_prev   = (cx_reg == '0) ? 8'd1 : cx_reg - 1'b1;
    assign col_next   = (cx_reg == geom.last_col) ? geom.last_col - 1'b1 : cx_reg + 1'b1;
    assign cell_first = (cx_reg == '0) && (cy_reg == '0);
    assign frame_end  = (cx_reg == geom.last_col) && (cy_reg == geom.last_row);

    always_comb
    begin
        unique case (nb_row(step_reg))
            OFF_PREV: nb_r = row_prev;
            OFF_SAME: nb_r = cy_reg;
            default:  nb_r = row_next;
        endcase
        unique case (nb_col(step_reg))
            OFF_PREV: nb_c = col_prev;
            OFF_SAME: nb_c = cx_reg;
            default:  nb_c = col_next;
        endcase
    end

    assign pix_raddr  = {nb_r, nb_c};
    assign prod_raddr = {step_reg[1] ? cy_reg : row_prev, step_reg[0] ? cx_reg : col_prev};
    assign nb_idx     = step_reg - 5'd1;
    assign pix_s      = $signed({3'b000, pix_rdata_reg});
    assign wx_s       = 11'(sobel_wx(nb_idx));
    assign wy_s       = 11'(sobel_wy(nb_idx));
    assign gx_w       = 22'(gx_reg);
    assign gy_w       = 22'(gy_reg);
    assign a_w        = 44'(a_reg);
    assign c_w        = 44'(c_reg);
    assign b_w        = 46'(b_reg);
    assign s_w        = 46'(a_reg) + 46'(c_reg);
    assign k_w        = 39'(harris_k);
    assign kfull      = {pk_hi_reg, 23'b0} + 62'(pk_lo_reg);
    assign spread     = max_reg > min_reg;
    assign span_w     = {1'b0, span_reg};
    assign trial      = (step_reg == '0) ? rem_reg : {rem_reg[RESP_W-1:0], 1'b0};
    assign ge         = trial >= span_w;

    assign pop        = (state_reg == S_IDLE) && cmd_valid;
    assign cmd_stall  = (state_reg != S_IDLE);
    assign pix_we     = pop && !cmd.is_query;
    assign prod_we    = (state_reg == S_SOBEL) && (step_reg == 5'd10);
    assign resp_we    = (state_reg == S_HARRIS) && (step_reg == 5'd9);
    assign load_out   = (state_reg == S_RESULT) && (!res_valid_reg || !result_stall);

    assign result       = result_reg;
    assign result_valid = res_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[cmd.addr] <= cmd.pixel;
        pix_rdata_reg <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prod_we)
        begin
            xx_mem[here] <= 20'(gx_w * gx_w);
            xy_mem[here] <= 21'(gx_w * gy_w);
            yy_mem[here] <= 20'(gy_w * gy_w);
        end
        xx_rdata_reg <= xx_mem[prod_raddr];
        xy_rdata_reg <= xy_mem[prod_raddr];
        yy_rdata_reg <= yy_mem[prod_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (resp_we)
            resp_mem[here] <= r_new_reg;
        resp_rdata_reg <= resp_mem[cmd.addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && cmd.is_query)
                begin
                    if (!frame_done_reg)
                        status_reg <= ST_NOT_DONE;
                    else if (cmd.outside)
                        status_reg <= ST_OUTSIDE;
                    else
                        status_reg <= ST_OK;
                    r_reg      <= '0;
                    q_reg      <= '0;
                    spread_reg <= 1'b0;
                end
            end
            S_SOBEL:
            begin
                if (step_reg == '0)
                begin
                    gx_reg <= '0;
                    gy_reg <= '0;
                end
                else if (step_reg <= 5'd9)
                begin
                    gx_reg <= gx_reg + 11'(wx_s * pix_s);
                    gy_reg <= gy_reg + 11'(wy_s * pix_s);
                end
            end
            S_HARRIS:
            begin
                unique case (step_reg)
                    5'd0:
                    begin
                        a_reg <= '0;
                        b_reg <= '0;
                        c_reg <= '0;
                    end
                    5'd1, 5'd2, 5'd3, 5'd4:
                    begin
                        a_reg <= a_reg + 22'(xx_rdata_reg);
                        b_reg <= b_reg + 23'(xy_rdata_reg);
                        c_reg <= c_reg + 22'(yy_rdata_reg);
                    end
                    5'd5:
                    begin
                        ac_reg <= 44'(a_w * c_w);
                        bb_reg <= 44'(b_w * b_w);
                        ss_reg <= s_w * s_w;
                    end
                    5'd6:
                    begin
                        pk_lo_reg <= k_w * 39'(ss_reg[22:0]);
                        pk_hi_reg <= k_w * 39'(ss_reg[45:23]);
                        diff_reg  <= $signed({1'b0, ac_reg}) - $signed({1'b0, bb_reg});
                    end
                    5'd7:
                        kterm_reg <= kfull[61:16];
                    5'd8:
                        r_new_reg <= 48'(diff_reg) - $signed({2'b00, kterm_reg});
                    default:
                    begin
                    end
                endcase
            end
            S_QREAD:
            begin
                r_reg      <= resp_rdata_reg;
                rem_reg    <= (RESP_W+1)'({resp_rdata_reg[RESP_W-1], resp_rdata_reg}
                                          - {min_reg[RESP_W-1], min_reg});
                span_reg   <= RESP_W'(max_reg - min_reg);
                spread_reg <= spread;
                q_reg      <= '0;
            end
            S_DIV:
            begin
                rem_reg <= ge ? trial - span_w : trial;
                q_reg   <= {q_reg[NORM_W-2:0], ge};
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    result_reg.status     <= status_reg;
                    result_reg.response   <= r_reg;
                    result_reg.normalized <= q_reg;
                    result_reg.is_corner  <= spread_reg && (q_reg >= corner_threshold);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            frame_done_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            min_reg        <= '0;
            max_reg        <= '0;
        end
        else
        begin
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
            if (restart)
                frame_done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (!cmd.is_query)
                        begin
                            if (cmd.first)
                                frame_done_reg <= 1'b0;
                            if (cmd.last)
                            begin
                                state_reg <= S_SOBEL;
                                step_reg  <= '0;
                                cx_reg    <= '0;
                                cy_reg    <= '0;
                            end
                        end
                        else if (!frame_done_reg || cmd.outside)
                            state_reg <= S_RESULT;
                        else
                            state_reg <= S_QREAD;
                    end
                end
                S_SOBEL:
                begin
                    if (step_reg == 5'd10)
                    begin
                        step_reg <= '0;
                        if (cx_reg == geom.last_col)
                        begin
                            cx_reg <= '0;
                            if (cy_reg == geom.last_row)
                            begin
                                cy_reg    <= '0;
                                state_reg <= S_HARRIS;
                            end
                            else
                                cy_reg <= cy_reg + 1'b1;
                        end
                        else
                            cx_reg <= cx_reg + 1'b1;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_HARRIS:
                begin
                    if (step_reg == 5'd9)
                    begin
                        step_reg <= '0;
                        if (cell_first || r_new_reg < min_reg)
                            min_reg <= r_new_reg;
                        if (cell_first || r_new_reg > max_reg)
                            max_reg <= r_new_reg;
                        if (frame_end)
                        begin
                            cx_reg         <= '0;
                            cy_reg         <= '0;
                            frame_done_reg <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else if (cx_reg == geom.last_col)
                        begin
                            cx_reg <= '0;
                            cy_reg <= cy_reg + 1'b1;
                        end
                        else
                            cx_reg <= cx_reg + 1'b1;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_QREAD:
                begin
                    step_reg  <= '0;
                    state_reg <= spread ? S_DIV : S_RESULT;
                end
                S_DIV:
                begin
                    if (step_reg == 5'(NORM_W - 1))
                        state_reg <= S_RESULT;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_RESULT:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/harris_corner_detector.sv -----
// Harris corner detector top level: configuration registers and part wiring.
//
// Items enter on item/item_valid/item_stall. A pixel write (action 0) stores the
// next pixel in raster order and returns nothing; a query (action 1) returns one
// result on result/result_valid/result_stall with status, raw response,
// min-max normalized response in Q16 and a corner flag.
// Configuration writes go through cfg_we/cfg_index/cfg_data, one per cycle.
// A four-entry queue sits between the intake and the back end, so items keep
// being accepted while the back end works or a result waits.
// Pixel writes are stored by the back end while it stays idle. The last pixel of
// a frame starts a compute pass: a Sobel pass over the pixel store, then the
// window sums and response, each stepped through the single read port of each
// store; queries wait behind it.
// A query whose frame is incomplete or whose coordinate is outside goes straight
// to its result; otherwise the stored response is read and, unless all responses
// are equal, normalized by the bit-serial divider before the result is presented.
// Reset clears registers to defaults and marks no frame complete; the stores
// hold nothing valid. A stalled result holds; the queue then fills and
// item_stall rises.
module harris_corner_detector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hcd_pkg::item_t            item,
    input  logic                      item_valid,
    output logic                      item_stall,
    output hcd_pkg::result_t          result,
    output logic                      result_valid,
    input  logic                      result_stall,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [hcd_pkg::CFG_W-1:0] cfg_data
);
    import hcd_pkg::*;

    logic [GEO_W-1:0] frame_width_reg, frame_height_reg;
    logic [K_W-1:0]   harris_k_reg;
    logic [THR_W-1:0] corner_threshold_reg;
    logic             restart;
    geom_t            geom;
    cmd_t             push_cmd, pop_cmd;
    logic             push_valid, push_stall, pop_valid, pop_stall;

    assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= 9'd256;
            frame_height_reg     <= 9'd256;
            harris_k_reg         <= 16'd2621;
            corner_threshold_reg <= 17'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[GEO_W-1:0];
                REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_data[GEO_W-1:0];
                REG_HARRIS_K:         harris_k_reg         <= cfg_data[K_W-1:0];
                REG_CORNER_THRESHOLD: corner_threshold_reg <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    hcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .restart      (restart),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (push_cmd),
        .cmd_valid    (push_valid),
        .cmd_stall    (push_stall),
        .geom         (geom)
    );

    hcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall)
    );

    hcd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .restart          (restart),
        .geom             (geom),
        .harris_k         (harris_k_reg),
        .corner_threshold (corner_threshold_reg),
        .cmd              (pop_cmd),
        .cmd_valid        (pop_valid),
        .cmd_stall        (pop_stall),
        .result           (result),
        .result_valid     (result_valid),
        .result_stall     (result_stall)
    );

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.response == '0 && result.normalized == '0 && !result.is_corner)
        else $error("error result carries nonzero fields");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.normalized <= 17'd65536)
        else $error("normalized response out of range");

    a_corner_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_corner |-> result.normalized >= corner_threshold_reg)
        else $error("corner flag below threshold");

endmodule

// ----- tb/sv/harris_corner_detector_tb.sv -----
// Self-checking testbench for the Harris corner detector: random frames and queries checked against a local predictor.
module harris_corner_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hcd_pkg::*;

    logic                 clk;
    logic                 rst_n;
    item_t                item;
    logic                 item_valid;
    logic                 item_stall;
    result_t              result;
    logic                 result_valid;
    logic                 result_stall;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    harris_corner_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    logic [7:0]    pix_mem [0:65535];
    longint        resp_mem [0:65535];
    int            grad_xx [0:65535];
    int            grad_xy [0:65535];
    int            grad_yy [0:65535];
    logic [8:0]    geo_w;
    logic [8:0]    geo_h;
    logic [15:0]   k_q16;
    logic [16:0]   thr_q16;
    int unsigned   wr_col;
    int unsigned   wr_row;
    bit            frame_done;
    longint        resp_min;
    longint        resp_max;

    result_t       expected_results [$];
    item_t         pending_items [$];
    int            issued_count;
    int            accepted_count;
    int            fail_count;
    int            gap_left;
    int            hold_left;
    int            press_count;
    int            press_seen;
    bit            idle_on;
    bit            stall_on;

    function automatic int unsigned clamp_geo(logic [8:0] v);
        if (v < 2) return 2;
        if (v > MAX_WIDTH) return 256;
        return 32'(v);
    endfunction

    function automatic int unsigned refl(int i, int unsigned n);
        if (i < 0) return 1;
        if (i >= int'(n)) return n - 2;
        return i;
    endfunction

    function automatic int pix_at(int y, int x, int unsigned w, int unsigned h);
        return int'(pix_mem[refl(y, h) * 256 + refl(x, w)]);
    endfunction

    task automatic compute_responses();
        int unsigned w, h, at;
        int          gx, gy, y, x, dy, dx;
        longint      a, b, c, r;
        logic [63:0] s, kterm;
        w = clamp_geo(geo_w);
        h = clamp_geo(geo_h);
        for (y = 0; y < int'(h); y++)
            for (x = 0; x < int'(w); x++)
            begin
                gx = pix_at(y - 1, x + 1, w, h) + 2 * pix_at(y, x + 1, w, h)
                   + pix_at(y + 1, x + 1, w, h) - pix_at(y - 1, x - 1, w, h)
                   - 2 * pix_at(y, x - 1, w, h) - pix_at(y + 1, x - 1, w, h);
                gy = pix_at(y + 1, x - 1, w, h) + 2 * pix_at(y + 1, x, w, h)
                   + pix_at(y + 1, x + 1, w, h) - pix_at(y - 1, x - 1, w, h)
                   - 2 * pix_at(y - 1, x, w, h) - pix_at(y - 1, x + 1, w, h);
                at = y * 256 + x;
                grad_xx[at] = gx * gx;
                grad_xy[at] = gx * gy;
                grad_yy[at] = gy * gy;
            end
        for (y = 0; y < int'(h); y++)
            for (x = 0; x < int'(w); x++)
            begin
                a = 0;
                b = 0;
                c = 0;
                for (dy = -1; dy <= 0; dy++)
                    for (dx = -1; dx <= 0; dx++)
                    begin
                        at = refl(y + dy, h) * 256 + refl(x + dx, w);
                        a += grad_xx[at];
                        b += grad_xy[at];
                        c += grad_yy[at];
                    end
                s = 64'(a + c);
                kterm = (64'(k_q16) * (s * s)) >> 16;
                r = a * c - b * b - longint'(kterm);
                resp_mem[y * 256 + x] = r;
                if ((y == 0 && x == 0) || r < resp_min) resp_min = r;
                if ((y == 0 && x == 0) || r > resp_max) resp_max = r;
            end
    endtask

    task automatic apply_item(item_t it);
        result_t     res;
        int unsigned w, h, qc, qr;
        longint      r;
        logic [63:0] span, off, quo;
        w = clamp_geo(geo_w);
        h = clamp_geo(geo_h);
        if (it.action == ACT_PIXEL)
        begin
            if (wr_col >= w || wr_row >= h)
            begin
                wr_col = 0;
                wr_row = 0;
            end
            if (wr_col == 0 && wr_row == 0) frame_done = 0;
            pix_mem[wr_row * 256 + wr_col] = it.pixel;
            wr_col++;
            if (wr_col >= w)
            begin
                wr_col = 0;
                wr_row++;
                if (wr_row >= h)
                begin
                    wr_row = 0;
                    compute_responses();
                    frame_done = 1;
                end
            end
        end
        else
        begin
            res = '0;
            qc = 32'(it.query_col);
            qr = 32'(it.query_row);
            if (!frame_done)
                res.status = ST_NOT_DONE;
            else if (qc >= w || qr >= h)
                res.status = ST_OUTSIDE;
            else
            begin
                res.status = ST_OK;
                r = resp_mem[qr * 256 + qc];
                res.response = r[47:0];
                if (resp_max > resp_min)
                begin
                    span = 64'(resp_max - resp_min);
                    off = 64'(r - resp_min) << 16;
                    quo = off / span;
                    res.normalized = quo[16:0];
                    res.is_corner = off >= 64'(thr_q16) * span;
                end
            end
            expected_results.push_back(res);
        end
    endtask

    function automatic item_t mk_pix(logic [7:0] p);
        item_t it;
        it.action = ACT_PIXEL;
        it.pixel = p;
        it.query_col = 8'($urandom);
        it.query_row = 8'($urandom);
        return it;
    endfunction

    function automatic item_t mk_query(int unsigned c, int unsigned r);
        item_t it;
        it.action = ACT_QUERY;
        it.pixel = 8'($urandom);
        it.query_col = c[7:0];
        it.query_row = r[7:0];
        return it;
    endfunction

    function automatic int pick_delay(bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_item(item_t it);
        pending_items.push_back(it);
        issued_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != issued_count || expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
            begin
                if (idx == REG_FRAME_WIDTH) geo_w = val[8:0];
                else geo_h = val[8:0];
                wr_col = 0;
                wr_row = 0;
                frame_done = 0;
            end
            REG_HARRIS_K: k_q16 = val[15:0];
            default: thr_q16 = val[16:0];
        endcase
    endtask

    task automatic run_phase(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv,
                             logic [CFG_W-1:0] kv, logic [CFG_W-1:0] tv);
        int unsigned w, h, mode, base;
        int          i, n;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
        write_reg(REG_HARRIS_K, kv);
        write_reg(REG_CORNER_THRESHOLD, tv);
        @(posedge clk);
        cfg_we <= 1'b0;
        idle_on = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
        w = clamp_geo(geo_w);
        h = clamp_geo(geo_h);
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        for (i = 0; i < int'(w * h); i++)
        begin
            case (mode)
                2: push_item(mk_pix(base[7:0]));
                3: push_item(mk_pix($urandom_range(0, 1) ? 8'd255 : 8'd0));
                default: push_item(mk_pix(8'($urandom)));
            endcase
            if ($urandom_range(0, 9) == 0)
                push_item(mk_query($urandom_range(0, w - 1), $urandom_range(0, h - 1)));
        end
        n = $urandom_range(6, 24);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                push_item(mk_query($urandom_range(0, 255), $urandom_range(0, 255)));
            else
                push_item(mk_query($urandom_range(0, w - 1), $urandom_range(0, h - 1)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                push_item(mk_pix(8'($urandom)));
            push_item(mk_query(0, 0));
            push_item(mk_query($urandom_range(0, 255), $urandom_range(0, 255)));
        end
        push_item(mk_query($urandom_range(0, w - 1), $urandom_range(0, h - 1)));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else if (!(item_valid && item_stall))
        begin
            if (item_valid)
            begin
                apply_item(item);
                accepted_count++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                gap_left <= pick_delay(idle_on);
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
            press_seen = 0;
        end
        else
        begin
            if (press_seen != press_count)
            begin
                press_seen = press_count;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= pick_delay(stall_on) != 0;
        end
    end

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transfer %p", $time, result);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result.status !== exp_res.status
                    || result.response !== exp_res.response
                    || result.normalized !== exp_res.normalized
                    || result.is_corner !== exp_res.is_corner)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_res, result);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int          phase, ew;
        logic [16:0] wv, hv, kv, tv;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        issued_count = 0;
        accepted_count = 0;
        fail_count = 0;
        press_count = 0;
        geo_w = 9'd256;
        geo_h = 9'd256;
        k_q16 = 16'd2621;
        thr_q16 = 17'd32768;
        wr_col = 0;
        wr_row = 0;
        frame_done = 0;
        resp_min = 0;
        resp_max = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_item(mk_query(0, 0));
        push_item(mk_query(255, 255));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 17'd1);
        write_reg(REG_FRAME_HEIGHT, 17'd0);
        @(posedge clk);
        cfg_we <= 1'b0;
        push_item(mk_pix(8'd0));
        push_item(mk_pix(8'd255));
        push_item(mk_pix(8'd255));
        push_item(mk_pix(8'd0));
        push_item(mk_query(0, 0));
        push_item(mk_query(1, 1));
        push_item(mk_query(2, 0));
        push_item(mk_query(0, 2));
        push_item(mk_query(255, 255));
        push_item(mk_pix(8'd7));
        push_item(mk_query(0, 0));
        push_item(mk_pix(8'd7));
        push_item(mk_pix(8'd7));
        push_item(mk_pix(8'd7));
        push_item(mk_query(1, 0));
        push_item(mk_query(0, 1));

        phase = 0;
        while (issued_count < 1620)
        begin
            case ($urandom_range(0, 4))
                0: kv = 17'd0;
                1: kv = 17'd65535;
                2: kv = 17'd2621;
                default: kv = 17'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0: tv = 17'd0;
                1: tv = 17'd65536;
                default: tv = 17'($urandom_range(0, 65536));
            endcase
            if (phase == 1)
            begin
                wv = 17'd511;
                hv = 17'd2;
            end
            else if (phase == 2)
            begin
                wv = 17'd2;
                hv = 17'd300;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: wv = 17'($urandom_range(0, 1));
                    1: wv = 17'h10000 | 17'($urandom_range(2, 6));
                    default: wv = 17'($urandom_range(2, 10));
                endcase
                ew = int'(clamp_geo(wv[8:0]));
                hv = (ew >= 32) ? 17'd2 : 17'($urandom_range(2, 64 / ew));
                if ($urandom_range(0, 9) == 0) hv = 17'($urandom_range(0, 1));
            end
            run_phase(wv, hv, kv, tv);
            if (phase % 9 == 3) press_count++;
            phase++;
        end
        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hcd_pkg.sv
rtl/hcd_front.sv
rtl/hcd_queue.sv
rtl/hcd_back.sv
rtl/harris_corner_detector.sv
tb/sv/harris_corner_detector_tb.sv
